// ----- rtl/core/pncm_pkg.sv -----
// Shared types, constants and color packing functions for the palette matcher.
package pncm_pkg;

  // Default palette depth
  localparam int PALETTE_SIZE_DEF = 256;

  // Request codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Distance arithmetic
  localparam int          DIST_W    = 10;
  localparam logic [9:0]  MAX_DIST  = 10'd765;
  localparam logic [7:0]  ALPHA_THR = 8'd127;

  // Controller to datapath commands
  typedef struct packed {
    logic load_wr;      // write one palette entry
    logic query_start;  // capture query color, clear scan state
    logic scan;         // scan is running
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_end;     // exact match seen or last entry compared
  } dp_stat_t;

  // floor(x / 255) for x up to 63 * 255
  function automatic logic [5:0] div255(input logic [13:0] x);
    logic [14:0] s;
    s = 15'(x) + 15'(x >> 8) + 15'd1;
    return s[13:8];
  endfunction

  // floor(c * 31 / 255)
  function automatic logic [4:0] to5(input logic [7:0] c);
    logic [13:0] x;
    logic [5:0]  q;
    x = 14'(c) * 14'd31;
    q = div255(x);
    return q[4:0];
  endfunction

  // floor(c * 63 / 255)
  function automatic logic [5:0] to6(input logic [7:0] c);
    logic [13:0] x;
    x = 14'(c) * 14'd63;
    return div255(x);
  endfunction

  // |a - b| on one channel
  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- rtl/core/pncm_ctrl.sv -----
// Controller state machine for the palette matcher: accepts requests, runs the scan.
module pncm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cmd,
  input  pncm_pkg::dp_stat_t stat,
  output pncm_pkg::dp_cmd_t  dp_cmd,
  output logic               busy,
  output logic               done
);
  import pncm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && (cmd == CMD_QUERY)) state_next = ST_FETCH;
      ST_FETCH: if (stat.scan_end) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Commands and handshake outputs
  assign dp_cmd.load_wr     = accept && (cmd == CMD_LOAD);
  assign dp_cmd.query_start = accept && (cmd == CMD_QUERY);
  assign dp_cmd.scan        = (state == ST_FETCH);
  assign busy               = (state != ST_IDLE);
  assign done               = (state == ST_DONE);

endmodule

// ----- rtl/core/pncm_dpath.sv -----
// Datapath for the palette matcher: palette memory, distance compare, color packing.
module pncm_dpath #(
  parameter int PALETTE_SIZE = pncm_pkg::PALETTE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pncm_pkg::dp_cmd_t  dp_cmd,
  output pncm_pkg::dp_stat_t stat,
  input  logic [7:0]         entry_index,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [7:0]         alpha,
  output logic [7:0]         nearest_index,
  output logic [15:0]        rgb565,
  output logic [15:0]        argb1555
);
  import pncm_pkg::*;

  localparam int            AW   = $clog2(PALETTE_SIZE);
  localparam logic [AW-1:0] LAST = AW'(PALETTE_SIZE - 1);

  logic [23:0]       mem [PALETTE_SIZE];
  logic              wr_en;
  logic [7:0]        q_red, q_green, q_blue;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic              issued_all;
  logic [23:0]       rdata;
  logic              cmp_valid;
  logic [AW-1:0]     cmp_addr;
  logic [DIST_W-1:0] cur_dist;
  logic [DIST_W-1:0] best_d;
  logic [AW-1:0]     best;
  logic              better;

  // Palette write, slots past the palette depth are dropped
  assign wr_en = dp_cmd.load_wr && ({24'd0, entry_index} < 32'(PALETTE_SIZE));

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(entry_index)] <= {red, green, blue};
  end

  // Registered read port, one entry per cycle
  assign rd_en = dp_cmd.scan && !issued_all;

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Read address sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr    <= '0;
      issued_all <= 1'b0;
      cmp_valid  <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
      if (dp_cmd.query_start) begin
        rd_addr    <= '0;
        issued_all <= 1'b0;
      end else if (rd_en) begin
        rd_addr <= rd_addr + 1'b1;
        if (rd_addr == LAST) issued_all <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) cmp_addr <= rd_addr;
  end

  // Manhattan distance of the entry just read
  assign cur_dist = DIST_W'(absdiff(rdata[23:16], q_red))
                  + DIST_W'(absdiff(rdata[15:8],  q_green))
                  + DIST_W'(absdiff(rdata[7:0],   q_blue));

  // Strictly smaller keeps the earliest minimum
  assign better = dp_cmd.scan && cmp_valid && (cur_dist < best_d);

  always_ff @(posedge clk) begin
    if (dp_cmd.query_start) begin
      best   <= '0;
      best_d <= MAX_DIST;
    end else if (better) begin
      best   <= cmp_addr;
      best_d <= cur_dist;
    end
  end

  // Stop on an exact match or after the last entry
  assign stat.scan_end = cmp_valid && ((cur_dist == '0) || (cmp_addr == LAST));

  // Query color capture and packing
  always_ff @(posedge clk) begin
    if (dp_cmd.query_start) begin
      q_red    <= red;
      q_green  <= green;
      q_blue   <= blue;
      rgb565   <= {to5(red), to6(green), to5(blue)};
      argb1555 <= {(alpha > ALPHA_THR), to5(red), to5(green), to5(blue)};
    end
  end

  assign nearest_index = 8'(best);

endmodule

// ----- rtl/core/palette_nearest_color_match_unit.sv -----
// Palette nearest-color matcher: top level joining controller and datapath.
// A load request completes at its accepting edge; busy stays low and no done strobe follows.
// A query scans one palette entry per cycle through the registered memory read port;
// done rises once the last entry has been compared, or sooner on an exact match.
// A new request is taken in the cycle after done.
// Synchronous reset returns the controller to idle; palette contents are undefined until loaded.
module palette_nearest_color_match_unit #(
  parameter int PALETTE_SIZE = pncm_pkg::PALETTE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  output logic        done,
  output logic [7:0]  nearest_index,
  output logic [15:0] rgb565,
  output logic [15:0] argb1555
);
  import pncm_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t stat;

  // Controller
  pncm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .stat   (stat),
    .dp_cmd (dp_cmd),
    .busy   (busy),
    .done   (done)
  );

  // Datapath
  pncm_dpath #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .stat          (stat),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .nearest_index (nearest_index),
    .rgb565        (rgb565),
    .argb1555      (argb1555)
  );

endmodule

// ----- rtl/core/pncm_checker.sv -----
// Port-level checks on the palette matcher's request and result timing, bound to the top level.
module pncm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cmd,
  input logic done
);
  import pncm_pkg::*;

  // A result strobe only appears while a query is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // A query request makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_QUERY)) |=> busy)
    else $error("query accepted but block not busy");

  // A load request produces no result and leaves the block free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_LOAD)) |=> (!busy && !done))
    else $error("load request stalled the block or produced a result");

  // One strobe per query, and the block is free right after it
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> (!done && !busy))
    else $error("result strobe repeated or block stayed busy");

endmodule

bind palette_nearest_color_match_unit pncm_checker u_pncm_checker (.*);

// ----- bench/palette_nearest_color_match_unit_tb.sv -----
// Self-checking testbench for the palette nearest-color matcher.
`timescale 1ns / 100ps

module palette_nearest_color_match_unit_tb;

  localparam int DEPTH      = pncm_pkg::PALETTE_SIZE_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 2000;
  localparam int TABLE_ROWS = 19;

  // One request as driven on the ports
  typedef struct packed {
    logic       cmd;
    logic [7:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } color_req_t;

  // One query answer
  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] p565;
    logic [15:0] p1555;
  } match_t;

  // Directed table row; known answer used when fixed is set
  typedef struct packed {
    logic        cmd;
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    bit          fixed;
    logic [7:0]  x_index;
    logic [15:0] x_565;
    logic [15:0] x_1555;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [7:0]  entry_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        done;
  logic [7:0]  nearest_index;
  logic [15:0] rgb565;
  logic [15:0] argb1555;

  logic [23:0] palette_copy [DEPTH];
  match_t      pending_matches [$];
  stim_row_t   directed_rows [TABLE_ROWS];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          burst_mode = 1'b0;

  palette_nearest_color_match_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .done          (done),
    .nearest_index (nearest_index),
    .rgb565        (rgb565),
    .argb1555      (argb1555)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Manhattan distance on one channel
  function automatic int chan_dist(input logic [7:0] x, input logic [7:0] y);
    return (x > y) ? int'(x) - int'(y) : int'(y) - int'(x);
  endfunction

  // Exact channel reduction to n bits
  function automatic int chan_scale(input logic [7:0] c, input int top);
    return (int'(c) * top) / 255;
  endfunction

  // Expected answer for a query against the current palette copy
  function automatic match_t predict_match(input color_req_t rq);
    match_t m;
    int     best;
    int     best_d;
    int     d;
    int     r5;
    int     g6;
    int     g5;
    int     b5;
    best   = 0;
    best_d = int'(pncm_pkg::MAX_DIST);
    // earliest strict minimum; exact hit stops the scan
    for (int i = 0; i < DEPTH; i++) begin
      d = chan_dist(palette_copy[i][23:16], rq.r) + chan_dist(palette_copy[i][15:8], rq.g)
        + chan_dist(palette_copy[i][7:0], rq.b);
      if (d == 0) begin
        best = i;
        break;
      end
      if (d < best_d) begin
        best   = i;
        best_d = d;
      end
    end
    r5 = chan_scale(rq.r, 31);
    g6 = chan_scale(rq.g, 63);
    g5 = chan_scale(rq.g, 31);
    b5 = chan_scale(rq.b, 31);
    m.index = best[7:0];
    m.p565  = {r5[4:0], g6[5:0], b5[4:0]};
    m.p1555 = {(rq.a > pncm_pkg::ALPHA_THR), r5[4:0], g5[4:0], b5[4:0]};
    return m;
  endfunction

  // Color drawn either from a few swatches (ties, extremes) or at random
  function automatic logic [23:0] pick_color();
    logic [23:0] swatch [8];
    swatch = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
               24'h0000ff, 24'h808080, 24'h55aaff, 24'h7f807f};
    if ($urandom_range(1, 0) == 0)
      return swatch[$urandom_range(7, 0)];
    return 24'($urandom);
  endfunction

  // Small offset around a channel value, clamped
  function automatic logic [7:0] jitter(input logic [7:0] c);
    int v;
    v = int'(c) + $urandom_range(6, 0) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR %0t: %s: got %h expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Drive one request, hold until accepted, then update the palette copy or record the expected answer
  task automatic issue_request(input color_req_t rq, input bit fixed, input match_t known);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    cmd         <= rq.cmd;
    entry_index <= rq.idx;
    red         <= rq.r;
    green       <= rq.g;
    blue        <= rq.b;
    alpha       <= rq.a;
    do @(posedge clk); while (busy);
    if (rq.cmd == pncm_pkg::CMD_LOAD)
      palette_copy[rq.idx] = {rq.r, rq.g, rq.b};
    else
      pending_matches.push_back(fixed ? known : predict_match(rq));
  endtask

  // Drop start and wait until every query has answered
  task automatic drain_queries();
    start <= 1'b0;
    do @(posedge clk); while (pending_matches.size() != 0);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    match_t want;
    if (!rst && done) begin
      if (pending_matches.size() == 0) begin
        report_mismatch("result with no query pending", {8'h00, nearest_index}, 16'h0000);
      end else begin
        want = pending_matches.pop_front();
        if (nearest_index !== want.index)
          report_mismatch("nearest_index", {8'h00, nearest_index}, {8'h00, want.index});
        if (rgb565 !== want.p565)
          report_mismatch("rgb565", rgb565, want.p565);
        if (argb1555 !== want.p1555)
          report_mismatch("argb1555", argb1555, want.p1555);
      end
    end
  end

  // Watchdog: cycles with neither a request taken nor a result seen
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    color_req_t  rq;
    match_t      known;
    logic [23:0] base;
    int          kind;

    rst         = 1'b1;
    start       = 1'b0;
    cmd         = pncm_pkg::CMD_LOAD;
    entry_index = '0;
    red         = '0;
    green       = '0;
    blue        = '0;
    alpha       = '0;
    known       = '0;
    for (int i = 0; i < DEPTH; i++) palette_copy[i] = '0;

    // query rows over an all-black palette first; loads then reshape it
    directed_rows[0]  = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
                          1'b1, 8'd0,   16'hffff, 16'hffff};
    directed_rows[1]  = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
                          1'b1, 8'd0,   16'h0000, 16'h0000};
    directed_rows[2]  = '{pncm_pkg::CMD_QUERY, 8'd255, 8'd255, 8'd255, 8'd255, 8'd127,
                          1'b1, 8'd0,   16'hffff, 16'h7fff};
    directed_rows[3]  = '{pncm_pkg::CMD_QUERY, 8'd255, 8'd0,   8'd0,   8'd0,   8'd128,
                          1'b1, 8'd0,   16'h0000, 16'h8000};
    directed_rows[4]  = '{pncm_pkg::CMD_LOAD,  8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[5]  = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
                          1'b1, 8'd255, 16'hffff, 16'hffff};
    directed_rows[6]  = '{pncm_pkg::CMD_LOAD,  8'd0,   8'd128, 8'd128, 8'd128, 8'd0,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[7]  = '{pncm_pkg::CMD_LOAD,  8'd1,   8'd128, 8'd128, 8'd128, 8'd0,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[8]  = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd128, 8'd128, 8'd128, 8'd64,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[9]  = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd130, 8'd129, 8'd127, 8'd200,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[10] = '{pncm_pkg::CMD_LOAD,  8'd2,   8'd120, 8'd128, 8'd128, 8'd0,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[11] = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd124, 8'd128, 8'd128, 8'd1,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[12] = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd85,  8'd170, 8'd255, 8'd200,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[13] = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd170, 8'd85,  8'd0,   8'd127,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[14] = '{pncm_pkg::CMD_LOAD,  8'd254, 8'd0,   8'd255, 8'd0,   8'd0,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[15] = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd0,   8'd250, 8'd5,   8'd128,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[16] = '{pncm_pkg::CMD_LOAD,  8'd100, 8'd1,   8'd2,   8'd3,   8'd0,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[17] = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd1,   8'd2,   8'd3,   8'd255,
                          1'b0, 8'd0,   16'h0000, 16'h0000};
    directed_rows[18] = '{pncm_pkg::CMD_QUERY, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
                          1'b0, 8'd0,   16'h0000, 16'h0000};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // load every slot with black so no query reads an unwritten entry
    for (int i = 0; i < DEPTH; i++) begin
      rq = '{pncm_pkg::CMD_LOAD, 8'(i), 8'd0, 8'd0, 8'd0, 8'($urandom)};
      issue_request(rq, 1'b0, known);
    end

    // directed table
    for (int i = 0; i < TABLE_ROWS; i++) begin
      rq = '{directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].r,
             directed_rows[i].g, directed_rows[i].b, directed_rows[i].a};
      known = '{directed_rows[i].x_index, directed_rows[i].x_565, directed_rows[i].x_1555};
      issue_request(rq, directed_rows[i].fixed, known);
    end
    drain_queries();

    // random mix: palette rewrites, exact hits, near misses, arbitrary colors
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(3, 0) == 0);
      if (n % 250 == 249) drain_queries();
      rq.idx = 8'($urandom);
      rq.a   = 8'($urandom);
      kind   = $urandom_range(99, 0);
      if (kind < 25) begin
        rq.cmd = pncm_pkg::CMD_LOAD;
        {rq.r, rq.g, rq.b} = pick_color();
      end else begin
        rq.cmd = pncm_pkg::CMD_QUERY;
        base = palette_copy[$urandom_range(DEPTH - 1, 0)];
        if (kind < 55)
          {rq.r, rq.g, rq.b} = base;
        else if (kind < 70)
          {rq.r, rq.g, rq.b} = {jitter(base[23:16]), jitter(base[15:8]), jitter(base[7:0])};
        else
          {rq.r, rq.g, rq.b} = pick_color();
      end
      issue_request(rq, 1'b0, known);
    end

    // wind down and let any stray strobe show up
    drain_queries();
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pncm_pkg.sv
rtl/core/pncm_ctrl.sv
rtl/core/pncm_dpath.sv
rtl/core/palette_nearest_color_match_unit.sv
rtl/core/pncm_checker.sv
bench/palette_nearest_color_match_unit_tb.sv
